// ===== rtl/psds_pkg.sv =====
// ----------------------------------------------------------------------------
// psds_pkg: shared constants for the prime sieve / divisor sum core
//
// Field widths, default limit, register reset value, sum ceiling, request
// kind codes and the bitmap fill and clear values.
// ----------------------------------------------------------------------------
package psds_pkg;

   localparam int NUMBER_W      = 15;
   localparam int SUM_W         = 17;
   localparam int LIMIT_W       = 16;
   localparam int MAX_LIMIT_DEF = 32768;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd32768;
   localparam logic [SUM_W-1:0]   SUM_MAX     = 17'd131071;

   localparam logic KIND_BUILD = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic MAP_FILL  = 1'b1;
   localparam logic MAP_CLEAR = 1'b0;

endpackage

// ===== rtl/prime_sieve_divisor_sum_core.sv =====
// ----------------------------------------------------------------------------
// prime_sieve_divisor_sum_core: prime bitmap and proper divisor sums
//
// Builds a sieve bitmap over 0..limit-1 and answers queries with the sum of
// proper divisors, a prime flag, an abundant flag and a range flag.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_kind, req_number
//  rsp      out        rsp_valid / rsp_ready  rsp_divisor_sum, rsp_is_prime,
//                                             rsp_abundant, rsp_out_of_range
//  csr      in         csr_wr_en              csr_wr_data (limit)
//
//  Build: fill the whole bitmap, then read the bit of each sieve index i
//  (i*i < limit); an index still marked clears each of its multiples below
//  the limit. A build ends with the hand-off of an all-zero response.
//  Query: one 15-step restoring divider tests each candidate divisor
//  d <= sqrt(n) and adds d and n/d together, d alone for d = 1 or d = n/d.
//  Out of range, 0 and 1 go straight to hand-off. One request at a time;
//  req_ready is low while busy. A finished response waits in the output
//  register under stall. The prime flag reads as zero until the first build.
// ----------------------------------------------------------------------------
module prime_sieve_divisor_sum_core #(
   parameter int MAX_LIMIT = psds_pkg::MAX_LIMIT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [psds_pkg::NUMBER_W-1:0] req_number,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [psds_pkg::SUM_W-1:0]    rsp_divisor_sum,
   output logic                          rsp_is_prime,
   output logic                          rsp_abundant,
   output logic                          rsp_out_of_range,

   input  logic                          csr_wr_en,
   input  logic [psds_pkg::LIMIT_W-1:0]  csr_wr_data
);

   localparam int NW    = psds_pkg::NUMBER_W;
   localparam int SW    = psds_pkg::SUM_W;
   localparam int AW    = (MAX_LIMIT > 1) ? $clog2(MAX_LIMIT) : 1;
   localparam int LW    = $clog2(MAX_LIMIT + 1);
   localparam int CW    = (LW > psds_pkg::LIMIT_W) ? LW : psds_pkg::LIMIT_W;
   localparam int DW    = NW + 2;
   localparam int CNT_W = $clog2(NW);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_TEST,
      S_CHECK,
      S_CLEAR,
      S_QTEST,
      S_QDIV,
      S_QACC,
      S_DONE
   } state_type;

   state_type state_ff;

   logic [psds_pkg::LIMIT_W-1:0] limit_ff;
   logic                         built_ff;
   logic [LW-1:0]                eff_lim_ff;
   logic [NW-1:0]                n_ff;

   logic [AW-1:0]                fill_addr_ff;
   logic [LW-1:0]                i_ff;
   logic [LW:0]                  isq_ff;
   logic [LW:0]                  j_ff;

   logic [NW-1:0]                d_ff;
   logic [DW-1:0]                dsq_ff;
   logic [NW-1:0]                rem_ff;
   logic [NW-1:0]                quo_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [SW-1:0]                sum_ff;

   logic [SW-1:0]                res_sum_ff;
   logic                         res_prime_ff;
   logic                         res_abundant_ff;
   logic                         res_oor_ff;

   logic                         rsp_valid_ff;
   logic [SW-1:0]                rsp_sum_ff;
   logic                         rsp_prime_ff;
   logic                         rsp_abundant_ff;
   logic                         rsp_oor_ff;

   logic                         map_mem [MAX_LIMIT];
   logic                         rd_data_ff;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic                         wr_data;

   logic [CW-1:0]                lim_ext;
   logic [LW-1:0]                eff_lim;
   logic                         accept;
   logic                         n_oor;
   logic [LW:0]                  eff_lim_x;
   logic [NW:0]                  rem_shift;
   logic [NW:0]                  rem_diff;
   logic                         rem_ge;
   logic [NW:0]                  add_val;
   logic [SW:0]                  sum_wide;

   // effective limit: clamp to 2..MAX_LIMIT
   always_comb begin
      lim_ext = CW'(limit_ff);
      if (lim_ext < CW'(2)) begin
         eff_lim = LW'(2);
      end else if (lim_ext > CW'(MAX_LIMIT)) begin
         eff_lim = LW'(MAX_LIMIT);
      end else begin
         eff_lim = LW'(lim_ext);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign n_oor     = CW'(req_number) >= CW'(eff_lim);
   assign eff_lim_x = {1'b0, eff_lim_ff};

   // restoring divider step
   assign rem_shift = {rem_ff, quo_ff[NW-1]};
   assign rem_diff  = rem_shift - {1'b0, d_ff};
   assign rem_ge    = rem_shift >= {1'b0, d_ff};

   // divisor pair d and n/d; n itself is left out for d = 1
   always_comb begin
      add_val = {1'b0, d_ff};
      if ((d_ff != NW'(1)) && (quo_ff != d_ff)) begin
         add_val = {1'b0, d_ff} + {1'b0, quo_ff};
      end
      sum_wide = {1'b0, sum_ff} + (SW+1)'(add_val);
   end

   // bitmap port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = AW'(req_number);
      wr_en   = 1'b0;
      wr_addr = fill_addr_ff;
      wr_data = psds_pkg::MAP_FILL;
      case (state_ff)
         S_IDLE: begin
            rd_en   = accept && (req_kind == psds_pkg::KIND_QUERY);
            rd_addr = AW'(req_number);
         end
         S_FILL: begin
            wr_en   = 1'b1;
            wr_addr = fill_addr_ff;
            wr_data = psds_pkg::MAP_FILL;
         end
         S_TEST: begin
            rd_en   = isq_ff < eff_lim_x;
            rd_addr = AW'(i_ff);
         end
         S_CLEAR: begin
            wr_en   = j_ff < eff_lim_x;
            wr_addr = AW'(j_ff);
            wr_data = psds_pkg::MAP_CLEAR;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         built_ff     <= 1'b0;
         limit_ff     <= psds_pkg::LIMIT_RESET;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  n_ff            <= req_number;
                  eff_lim_ff      <= eff_lim;
                  res_sum_ff      <= '0;
                  res_prime_ff    <= 1'b0;
                  res_abundant_ff <= 1'b0;
                  res_oor_ff      <= 1'b0;
                  if (req_kind == psds_pkg::KIND_BUILD) begin
                     fill_addr_ff <= '0;
                     built_ff     <= 1'b1;
                     state_ff     <= S_FILL;
                  end else if (n_oor) begin
                     res_oor_ff <= 1'b1;
                     state_ff   <= S_DONE;
                  end else if (req_number < NW'(2)) begin
                     res_sum_ff <= SW'(req_number);
                     state_ff   <= S_DONE;
                  end else begin
                     d_ff     <= NW'(1);
                     dsq_ff   <= DW'(1);
                     sum_ff   <= '0;
                     state_ff <= S_QTEST;
                  end
               end
            end

            S_FILL: begin
               fill_addr_ff <= fill_addr_ff + AW'(1);
               if (fill_addr_ff == AW'(MAX_LIMIT - 1)) begin
                  i_ff     <= LW'(2);
                  isq_ff   <= (LW+1)'(4);
                  state_ff <= S_TEST;
               end
            end

            S_TEST: begin
               if (isq_ff < eff_lim_x) begin
                  state_ff <= S_CHECK;
               end else begin
                  state_ff <= S_DONE;
               end
            end

            S_CHECK: begin
               if (rd_data_ff) begin
                  j_ff     <= {i_ff, 1'b0};
                  state_ff <= S_CLEAR;
               end else begin
                  isq_ff   <= isq_ff + {i_ff, 1'b1};
                  i_ff     <= i_ff + LW'(1);
                  state_ff <= S_TEST;
               end
            end

            S_CLEAR: begin
               if (j_ff < eff_lim_x) begin
                  j_ff <= j_ff + (LW+1)'(i_ff);
               end else begin
                  isq_ff   <= isq_ff + {i_ff, 1'b1};
                  i_ff     <= i_ff + LW'(1);
                  state_ff <= S_TEST;
               end
            end

            S_QTEST: begin
               if (dsq_ff > DW'(n_ff)) begin
                  res_sum_ff      <= sum_ff;
                  res_prime_ff    <= built_ff & rd_data_ff;
                  res_abundant_ff <= sum_ff > SW'(n_ff);
                  state_ff        <= S_DONE;
               end else begin
                  rem_ff   <= '0;
                  quo_ff   <= n_ff;
                  cnt_ff   <= '0;
                  state_ff <= S_QDIV;
               end
            end

            S_QDIV: begin
               if (rem_ge) begin
                  rem_ff <= rem_diff[NW-1:0];
               end else begin
                  rem_ff <= rem_shift[NW-1:0];
               end
               quo_ff <= {quo_ff[NW-2:0], rem_ge};
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(NW - 1)) begin
                  state_ff <= S_QACC;
               end
            end

            S_QACC: begin
               if (rem_ff == '0) begin
                  if (sum_wide > (SW+1)'(psds_pkg::SUM_MAX)) begin
                     sum_ff <= psds_pkg::SUM_MAX;
                  end else begin
                     sum_ff <= sum_wide[SW-1:0];
                  end
               end
               dsq_ff   <= dsq_ff + DW'({d_ff, 1'b1});
               d_ff     <= d_ff + NW'(1);
               state_ff <= S_QTEST;
            end

            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_sum_ff      <= res_sum_ff;
                  rsp_prime_ff    <= res_prime_ff;
                  rsp_abundant_ff <= res_abundant_ff;
                  rsp_oor_ff      <= res_oor_ff;
                  state_ff        <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_divisor_sum  = rsp_sum_ff;
   assign rsp_is_prime     = rsp_prime_ff;
   assign rsp_abundant     = rsp_abundant_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   a_div_exact: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QACC) |->
         ((2*NW)'(quo_ff) * (2*NW)'(d_ff) + (2*NW)'(rem_ff) == (2*NW)'(n_ff)))
      else $error("divider result does not reproduce the dividend");

   a_clear_in_range: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (wr_data == psds_pkg::MAP_CLEAR)) |-> (j_ff < eff_lim_x))
      else $error("sieve cleared a bit at or above the limit");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside of hand-off");

   a_oor_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oor_ff) |->
         ((rsp_sum_ff == '0) && !rsp_prime_ff && !rsp_abundant_ff))
      else $error("out of range response carries data");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QACC) |-> (rem_ff < d_ff))
      else $error("divider remainder not below divisor");

endmodule

// ===== tb/sv/prime_sieve_divisor_sum_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_sieve_divisor_sum_core_test: self-checking bench for the sieve core
//
// Starts with a directed table that covers the limit extremes, queries before
// any build, out-of-range numbers and a stale bitmap after the limit is raised.
// Random phases follow, each with a new limit and mostly a fresh build. An
// in-bench bitmap and trial-division model predicts every response that the
// table does not fix. Both channels stall at random outside steady-flow phases.
// ----------------------------------------------------------------------------
module prime_sieve_divisor_sum_core_test;

   localparam int          MAP_DEPTH      = psds_pkg::MAX_LIMIT_DEF;
   localparam int          RANDOM_PHASES  = 6;
   localparam int unsigned WATCHDOG_LIMIT = 400000;

   typedef struct packed {
      logic [psds_pkg::SUM_W-1:0] divisor_sum;
      logic                       is_prime;
      logic                       abundant;
      logic                       out_of_range;
   } answer_type;

   typedef enum logic [1:0] {STEP_CONFIG, STEP_BUILD, STEP_QUERY} step_type;

   typedef struct packed {
      step_type                     step;
      logic [psds_pkg::LIMIT_W-1:0] value;
      logic                         typed;
      answer_type                   answer;
   } stim_row_type;

   localparam answer_type NO_ANSWER    = '0;
   localparam answer_type UNIT_SUM     = '{17'd1, 1'b0, 1'b0, 1'b0};
   localparam answer_type PRIME_ANSWER = '{17'd1, 1'b1, 1'b0, 1'b0};
   localparam answer_type BEYOND_LIMIT = '{17'd0, 1'b0, 1'b0, 1'b1};

   stim_row_type directed_rows [26] = '{
      '{STEP_QUERY,  16'd0,     1'b1, NO_ANSWER},
      '{STEP_QUERY,  16'd1,     1'b1, UNIT_SUM},
      '{STEP_QUERY,  16'd7,     1'b1, UNIT_SUM},
      '{STEP_QUERY,  16'd32767, 1'b0, NO_ANSWER},
      '{STEP_CONFIG, 16'd0,     1'b0, NO_ANSWER},
      '{STEP_QUERY,  16'd2,     1'b1, BEYOND_LIMIT},
      '{STEP_QUERY,  16'd1,     1'b1, UNIT_SUM},
      '{STEP_CONFIG, 16'd100,   1'b0, NO_ANSWER},
      '{STEP_BUILD,  16'd0,     1'b1, NO_ANSWER},
      '{STEP_QUERY,  16'd97,    1'b1, PRIME_ANSWER},
      '{STEP_QUERY,  16'd12,    1'b0, NO_ANSWER},
      '{STEP_QUERY,  16'd100,   1'b1, BEYOND_LIMIT},
      '{STEP_CONFIG, 16'd1000,  1'b0, NO_ANSWER},
      '{STEP_QUERY,  16'd999,   1'b0, NO_ANSWER},
      '{STEP_QUERY,  16'd945,   1'b0, NO_ANSWER},
      '{STEP_CONFIG, 16'd65535, 1'b0, NO_ANSWER},
      '{STEP_QUERY,  16'd32767, 1'b0, NO_ANSWER},
      '{STEP_BUILD,  16'd32767, 1'b1, NO_ANSWER},
      '{STEP_QUERY,  16'd32749, 1'b0, NO_ANSWER},
      '{STEP_QUERY,  16'd30240, 1'b0, NO_ANSWER},
      '{STEP_QUERY,  16'd16384, 1'b0, NO_ANSWER},
      '{STEP_CONFIG, 16'd1,     1'b0, NO_ANSWER},
      '{STEP_BUILD,  16'd5,     1'b1, NO_ANSWER},
      '{STEP_QUERY,  16'd0,     1'b1, NO_ANSWER},
      '{STEP_QUERY,  16'd1,     1'b1, UNIT_SUM},
      '{STEP_QUERY,  16'd3,     1'b1, BEYOND_LIMIT}
   };

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   logic                          req_kind    = psds_pkg::KIND_QUERY;
   logic [psds_pkg::NUMBER_W-1:0] req_number  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   logic [psds_pkg::SUM_W-1:0]    rsp_divisor_sum;
   logic                          rsp_is_prime;
   logic                          rsp_abundant;
   logic                          rsp_out_of_range;
   logic                          csr_wr_en   = 1'b0;
   logic [psds_pkg::LIMIT_W-1:0]  csr_wr_data = '0;

   bit                            prime_bits [MAP_DEPTH];
   logic [psds_pkg::LIMIT_W-1:0]  sieve_limit = psds_pkg::LIMIT_RESET;
   answer_type                    pending_answers [$];
   int unsigned                   error_count = 0;
   int unsigned                   idle_cycles = 0;
   int unsigned                   ready_hold  = 0;
   bit                            steady_flow = 1'b0;

   prime_sieve_divisor_sum_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_number       (req_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_divisor_sum  (rsp_divisor_sum),
      .rsp_is_prime     (rsp_is_prime),
      .rsp_abundant     (rsp_abundant),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned effective_limit();
      int unsigned lim;
      lim = sieve_limit;
      if (lim < 2) lim = 2;
      if (lim > MAP_DEPTH) lim = MAP_DEPTH;
      return lim;
   endfunction

   function automatic void rebuild_sieve();
      int unsigned lim;
      int unsigned i;
      int unsigned j;
      lim = effective_limit();
      foreach (prime_bits[k]) prime_bits[k] = psds_pkg::MAP_FILL;
      for (i = 2; i * i < lim; i++)
         if (prime_bits[i])
            for (j = i + i; j < lim; j += i) prime_bits[j] = psds_pkg::MAP_CLEAR;
   endfunction

   function automatic int unsigned proper_divisor_total(int unsigned n);
      int unsigned total;
      int unsigned d;
      total = 0;
      if (n == 0) return 0;
      if (n == 1) return 1;
      for (d = 1; d <= n / 2; d++)
         if (n % d == 0) begin
            total += d;
            if (total > psds_pkg::SUM_MAX) total = psds_pkg::SUM_MAX;
         end
      return total;
   endfunction

   function automatic answer_type predict_answer(logic kind,
                                                 logic [psds_pkg::NUMBER_W-1:0] number);
      answer_type  ans;
      int unsigned n;
      int unsigned total;
      ans = '0;
      n = number;
      if (kind == psds_pkg::KIND_BUILD) begin
         rebuild_sieve();
         return ans;
      end
      if (n >= effective_limit()) begin
         ans.out_of_range = 1'b1;
         return ans;
      end
      total = proper_divisor_total(n);
      ans.divisor_sum = total[psds_pkg::SUM_W-1:0];
      ans.is_prime = (n >= 2) && prime_bits[n];
      ans.abundant = total > n;
      return ans;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(20, 300);
   endfunction

   function automatic logic [psds_pkg::NUMBER_W-1:0] pick_number(int unsigned lim);
      int unsigned r;
      int unsigned n;
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(0, lim - 1);
      else if (r < 85) n = lim - 1 + $urandom_range(0, 2);
      else n = $urandom_range(0, 32767);
      if (n > 32767) n = 32767;
      return n[psds_pkg::NUMBER_W-1:0];
   endfunction

   function automatic void check_field(string what, int unsigned want,
                                       int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, what, want, got);
         error_count++;
      end
   endfunction

   task automatic send_request(logic kind, logic [psds_pkg::NUMBER_W-1:0] number,
                               logic typed, answer_type typed_answer);
      int unsigned gap;
      answer_type  predicted;
      gap = steady_flow ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_number <= number;
      do @(posedge clock); while (!req_ready);
      predicted = predict_answer(kind, number);
      pending_answers.push_back(typed ? typed_answer : predicted);
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(logic [psds_pkg::LIMIT_W-1:0] value);
      drain_answers();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sieve_limit = value;
   endtask

   always @(posedge clock) begin
      if (reset || steady_flow) begin
         rsp_ready  <= ~reset;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 2) != 0) begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(1, 40);
      end else begin
         rsp_ready  <= 1'b0;
         ready_hold <= 1 + pick_gap();
      end
   end

   always @(posedge clock) begin : check_responses
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: response expected none got sum %0d prime %0d abundant %0d oor %0d",
                     $time, rsp_divisor_sum, rsp_is_prime, rsp_abundant, rsp_out_of_range);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            check_field("divisor_sum", want.divisor_sum, rsp_divisor_sum);
            check_field("is_prime", want.is_prime, rsp_is_prime);
            check_field("abundant", want.abundant, rsp_abundant);
            check_field("out_of_range", want.out_of_range, rsp_out_of_range);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      stim_row_type row;
      int unsigned  pick;
      int unsigned  new_limit;
      int unsigned  count;
      int unsigned  phase;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         case (row.step)
            STEP_CONFIG: write_limit(row.value);
            STEP_BUILD:  send_request(psds_pkg::KIND_BUILD,
                                      row.value[psds_pkg::NUMBER_W-1:0], row.typed,
                                      row.answer);
            default:     send_request(psds_pkg::KIND_QUERY,
                                      row.value[psds_pkg::NUMBER_W-1:0], row.typed,
                                      row.answer);
         endcase
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) new_limit = $urandom_range(2, 400);
         else if (pick < 80) new_limit = $urandom_range(401, 4000);
         else if (pick < 88) new_limit = $urandom_range(0, 1);
         else new_limit = $urandom_range(0, 65535);
         write_limit(new_limit[psds_pkg::LIMIT_W-1:0]);
         steady_flow = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 85)
            send_request(psds_pkg::KIND_BUILD, pick_number(32768), 1'b0, NO_ANSWER);
         count = $urandom_range(10, 14);
         repeat (count) begin
            if ($urandom_range(0, 99) < 3)
               send_request(psds_pkg::KIND_BUILD, pick_number(32768), 1'b0, NO_ANSWER);
            else
               send_request(psds_pkg::KIND_QUERY, pick_number(effective_limit()), 1'b0,
                            NO_ANSWER);
         end
      end

      steady_flow = 1'b0;
      drain_answers();
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
